// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

	// Field widths of the channel payloads.
	localparam int TAG_W   = 16;
	localparam int LEVEL_W = 8;
	localparam int OCC_W   = 7;

	// Defaults for the top-level parameters.
	localparam int CAPACITY_DEF   = 64;
	localparam int TAG_BITS_DEF   = 16;
	localparam int LEVEL_BITS_DEF = 8;

	// Operation codes of a request.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SERVE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Status codes of a response.
	localparam logic [1:0] ST_SERVED = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [TAG_W-1:0]   tag;
		logic [LEVEL_W-1:0] severity;
	} req_t;

	typedef struct packed {
		logic [TAG_W-1:0] served_tag;
		logic [1:0]       status;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// Shift commands broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic srv;
	} cell_ctl_t;

endpackage

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell #(
	parameter int TW = spq_pkg::TAG_W,
	parameter int LW = spq_pkg::LEVEL_W
) (
	input  logic              clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic [TW-1:0]     new_tag,
	input  logic [LW-1:0]     new_level,
	input  logic              occupied,
	input  logic              prev_ge,
	input  logic [TW-1:0]     prev_tag,
	input  logic [LW-1:0]     prev_level,
	input  logic [TW-1:0]     next_tag,
	input  logic [LW-1:0]     next_level,
	output logic              ge,
	output logic [TW-1:0]     tag,
	output logic [LW-1:0]     level
);

	logic [TW-1:0] tag_q;
	logic [LW-1:0] level_q;

	// The chain is sorted, so the cells that stay put on an insert form a prefix.
	assign ge    = occupied && (level_q >= new_level);
	assign tag   = tag_q;
	assign level = level_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !ge) begin
			if (prev_ge) begin
				tag_q   <= new_tag;
				level_q <= new_level;
			end else begin
				tag_q   <= prev_tag;
				level_q <= prev_level;
			end
		end else if (ctl.srv) begin
			tag_q   <= next_tag;
			level_q <= next_level;
		end
	end

endmodule

// ===== rtl/stable_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Stable max-priority queue built as a sorted chain of cells.
// Requests arrive on req (req_valid / req_stall): an insert places a tag
// behind every held entry of equal or higher severity, a serve removes the
// front entry, and a clear empties the queue. Responses leave on rsp
// (rsp_valid / rsp_stall): one for every serve and for every insert that
// finds the queue full; accepted inserts and clears give no response.
// Every cell compares the new severity with its own in parallel and shifts
// toward its neighbor in the same cycle, so one request is taken each cycle
// while req_stall is low; its response is registered in the cycle after the transfer.
// Throughput is one request per cycle while req_stall is low, set by the parallel cell update.
// Reset empties the queue and drops any pending response; cell contents
// are not cleared since only occupied cells are ever read.
// While a response waits under rsp_stall, req_stall is raised, so no
// request is taken until that response transfers.
module stable_priority_queue_unit #(
	parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS   = spq_pkg::TAG_BITS_DEF,
	parameter int LEVEL_BITS = spq_pkg::LEVEL_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	localparam int TW = (TAG_BITS < spq_pkg::TAG_W) ? TAG_BITS : spq_pkg::TAG_W;
	localparam int LW = (LEVEL_BITS < spq_pkg::LEVEL_W) ? LEVEL_BITS : spq_pkg::LEVEL_W;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]      count_q;
	logic               rsp_valid_q;
	spq_pkg::rsp_t      rsp_q;

	logic               accept;
	logic               full;
	logic               empty;
	logic [TW-1:0]      new_tag;
	logic [LW-1:0]      new_level;
	spq_pkg::cell_ctl_t ctl;

	logic               cell_ge    [CAPACITY];
	logic [TW-1:0]      cell_tag   [CAPACITY];
	logic [LW-1:0]      cell_level [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign new_tag   = req.tag[TW-1:0];
	assign new_level = req.severity[LW-1:0];

	assign ctl.ins = accept && (req.op == spq_pkg::OP_INSERT) && !full;
	assign ctl.srv = accept && (req.op == spq_pkg::OP_SERVE) && !empty;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic          prev_ge;
		logic [TW-1:0] prev_tag;
		logic [LW-1:0] prev_level;
		logic [TW-1:0] next_tag;
		logic [LW-1:0] next_level;

		if (i == 0) begin : g_head
			assign prev_ge    = 1'b1;
			assign prev_tag   = '0;
			assign prev_level = '0;
		end else begin : g_body
			assign prev_ge    = cell_ge[i-1];
			assign prev_tag   = cell_tag[i-1];
			assign prev_level = cell_level[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_tag   = '0;
			assign next_level = '0;
		end else begin : g_inner
			assign next_tag   = cell_tag[i+1];
			assign next_level = cell_level[i+1];
		end

		spq_cell #(
			.TW(TW),
			.LW(LW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.new_tag   (new_tag),
			.new_level (new_level),
			.occupied  (count_q > CW'(i)),
			.prev_ge   (prev_ge),
			.prev_tag  (prev_tag),
			.prev_level(prev_level),
			.next_tag  (next_tag),
			.next_level(next_level),
			.ge        (cell_ge[i]),
			.tag       (cell_tag[i]),
			.level     (cell_level[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				case (req.op)
					spq_pkg::OP_INSERT: begin
						if (full) begin
							rsp_valid_q <= 1'b1;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					spq_pkg::OP_SERVE: begin
						rsp_valid_q <= 1'b1;
						if (!empty) begin
							count_q <= count_q - CW'(1);
						end
					end
					spq_pkg::OP_CLEAR: begin
						count_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Response payload; only loaded on a transfer that produces a response.
	always_ff @(posedge clk) begin
		if (accept && (req.op == spq_pkg::OP_INSERT) && full) begin
			rsp_q.served_tag <= '0;
			rsp_q.status     <= spq_pkg::ST_FULL;
			rsp_q.occupancy  <= spq_pkg::OCC_W'(count_q);
		end else if (accept && (req.op == spq_pkg::OP_SERVE)) begin
			if (empty) begin
				rsp_q.served_tag <= '0;
				rsp_q.status     <= spq_pkg::ST_EMPTY;
				rsp_q.occupancy  <= '0;
			end else begin
				rsp_q.served_tag <= spq_pkg::TAG_W'(cell_tag[0]);
				rsp_q.status     <= spq_pkg::ST_SERVED;
				rsp_q.occupancy  <= spq_pkg::OCC_W'(count_q - CW'(1));
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/spq_order_checker.sv =====
`timescale 1ns / 1ps

module spq_order_checker #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  spq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  spq_pkg::rsp_t rsp,
	output int            mismatches,
	output int            awaited
);

	// Entries held in serve order, front at index zero.
	logic [spq_pkg::TAG_W-1:0]   held_tag   [$];
	logic [spq_pkg::LEVEL_W-1:0] held_level [$];
	spq_pkg::rsp_t               awaited_rsp [$];
	int                          errors = 0;

	assign mismatches = errors;

	task automatic apply_request(input spq_pkg::req_t r);
		spq_pkg::rsp_t due;
		int            pos;
		due = '0;
		case (r.op)
			spq_pkg::OP_INSERT: begin
				if (held_tag.size() >= CAPACITY) begin
					due.status    = spq_pkg::ST_FULL;
					due.occupancy = spq_pkg::OCC_W'(held_tag.size());
					awaited_rsp.push_back(due);
				end else begin
					// The new entry goes behind every entry of equal or higher severity.
					pos = 0;
					while (pos < held_level.size() && held_level[pos] >= r.severity)
						pos++;
					held_tag.insert(pos, r.tag);
					held_level.insert(pos, r.severity);
				end
			end
			spq_pkg::OP_SERVE: begin
				if (held_tag.size() == 0) begin
					due.status = spq_pkg::ST_EMPTY;
				end else begin
					due.served_tag = held_tag.pop_front();
					void'(held_level.pop_front());
					due.status    = spq_pkg::ST_SERVED;
					due.occupancy = spq_pkg::OCC_W'(held_tag.size());
				end
				awaited_rsp.push_back(due);
			end
			spq_pkg::OP_CLEAR: begin
				held_tag.delete();
				held_level.delete();
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		spq_pkg::rsp_t due;
		if (!arst_n) begin
			held_tag.delete();
			held_level.delete();
			awaited_rsp.delete();
			awaited = 0;
		end else begin
			// The request is applied first, so a response that shares this edge with
			// a request still meets the older expectation at the front.
			if (req_valid && !req_stall)
				apply_request(req);
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected transfer: tag %h status %0d occupancy %0d",
							rsp.served_tag, rsp.status, rsp.occupancy);
				end else begin
					due = awaited_rsp.pop_front();
					if (rsp.served_tag !== due.served_tag || rsp.status !== due.status ||
							rsp.occupancy !== due.occupancy) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: expected tag %h status %0d occupancy %0d,",
								" got tag %h status %0d occupancy %0d"},
								due.served_tag, due.status, due.occupancy,
								rsp.served_tag, rsp.status, rsp.occupancy);
					end
				end
			end
			awaited = awaited_rsp.size();
		end
	end

endmodule

// ===== verif/tb_stable_priority_queue_unit.sv =====
`timescale 1ns / 1ps

module tb_stable_priority_queue_unit;

	localparam int         WATCH_LIMIT = 2000;
	localparam int         ITEM_TARGET = 850;
	localparam logic [1:0] OP_UNUSED   = 2'd3;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          rsp_stall = 1'b0;
	spq_pkg::req_t req       = '0;
	logic          req_stall;
	logic          rsp_valid;
	spq_pkg::rsp_t rsp;
	int            mismatches;
	int            awaited;
	bit            calm = 1'b0;
	int            sent = 0;
	int            quiet = 0;

	always #5 clk = ~clk;

	stable_priority_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	spq_order_checker order_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always @(posedge clk) begin
		rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
	end

	// Ends the run when no transfer happens on either channel for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else if (quiet == WATCH_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [spq_pkg::TAG_W-1:0] any_tag();
		return spq_pkg::TAG_W'($urandom);
	endfunction

	function automatic logic [spq_pkg::LEVEL_W-1:0] any_level();
		return spq_pkg::LEVEL_W'($urandom);
	endfunction

	function automatic logic [spq_pkg::LEVEL_W-1:0] level_upto(input int top);
		return spq_pkg::LEVEL_W'($urandom_range(0, top));
	endfunction

	task automatic offer(input logic [1:0] op, input logic [spq_pkg::TAG_W-1:0] tag,
			input logic [spq_pkg::LEVEL_W-1:0] severity);
		spq_pkg::req_t item;
		item.op       = op;
		item.tag      = tag;
		item.severity = severity;
		while (!calm && $urandom_range(0, 99) < 28) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (op != OP_UNUSED)
			sent++;
	endtask

	// Holds the sender back until every awaited response has transferred.
	task automatic settle();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (awaited != 0);
		@(posedge clk);
	endtask

	initial begin
		int seq;
		int kind;
		bit narrow;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Extremes of the fields, ties at top and bottom, an unused opcode,
		// serving past empty, and a clear in the middle of a case.
		offer(spq_pkg::OP_SERVE, any_tag(), any_level());
		offer(spq_pkg::OP_INSERT, 16'h0000, 8'h00);
		offer(spq_pkg::OP_INSERT, 16'hFFFF, 8'hFF);
		offer(spq_pkg::OP_INSERT, 16'h1111, 8'h80);
		offer(spq_pkg::OP_INSERT, 16'h2222, 8'h80);
		offer(spq_pkg::OP_INSERT, 16'h3333, 8'hFF);
		offer(spq_pkg::OP_INSERT, 16'hAAAA, 8'h00);
		offer(OP_UNUSED, 16'h5555, 8'h55);
		repeat (7) offer(spq_pkg::OP_SERVE, any_tag(), any_level());
		offer(spq_pkg::OP_INSERT, 16'h1234, 8'h7F);
		offer(spq_pkg::OP_INSERT, 16'h4321, 8'h01);
		offer(spq_pkg::OP_CLEAR, any_tag(), any_level());
		offer(spq_pkg::OP_SERVE, any_tag(), any_level());
		offer(spq_pkg::OP_INSERT, 16'hBEEF, 8'h10);
		offer(spq_pkg::OP_SERVE, any_tag(), any_level());
		settle();

		seq = 0;
		while (sent < ITEM_TARGET) begin
			calm <= (seq >= 8 && seq < 12);
			kind = (seq == 0) ? 0 : $urandom_range(0, 9);
			if (kind == 0) begin
				// Fill past capacity with few severities, then serve past empty.
				offer(spq_pkg::OP_CLEAR, any_tag(), any_level());
				repeat (spq_pkg::CAPACITY_DEF + $urandom_range(1, 4))
					offer(spq_pkg::OP_INSERT, any_tag(), level_upto(3));
				repeat (spq_pkg::CAPACITY_DEF + 2)
					offer(spq_pkg::OP_SERVE, any_tag(), any_level());
			end else if (kind == 1) begin
				repeat ($urandom_range(2, 6))
					offer(2'($urandom_range(0, 3)), any_tag(), any_level());
			end else begin
				narrow = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 3) != 0)
					offer(spq_pkg::OP_CLEAR, any_tag(), any_level());
				repeat ($urandom_range(8, 40)) begin
					if ($urandom_range(0, 99) < 60)
						offer(spq_pkg::OP_INSERT, any_tag(),
							narrow ? level_upto(3) : any_level());
					else
						offer(spq_pkg::OP_SERVE, any_tag(), any_level());
				end
				repeat ($urandom_range(0, 5))
					offer(spq_pkg::OP_SERVE, any_tag(), any_level());
			end
			if (seq % 6 == 5)
				settle();
			seq++;
		end

		calm <= 1'b0;
		settle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== stable_priority_queue_unit.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_unit.sv
verif/spq_order_checker.sv
verif/tb_stable_priority_queue_unit.sv
